### src/bqf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqf_pkg
// Shared types, widths and register codes of the multichannel biquad filter.
// ----------------------------------------------------------------------------
package bqf_pkg;

	localparam int MAX_CHANNELS_DEF = 8;
	localparam int SAMPLE_W         = 24;
	localparam int COEF_W           = 32;
	localparam int COUNT_W          = 4;
	localparam int CFG_IDX_W        = 3;
	localparam int CHIDX_W          = 3;

	localparam logic [CFG_IDX_W-1:0] REG_B0    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_B1    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B2    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_A1    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_A2    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd5;

	localparam logic signed [COEF_W-1:0] COEF_UNITY = 32'sh1000_0000;
	localparam logic [COUNT_W-1:0]       COUNT_RST  = 4'd1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_val_t;

	typedef struct packed {
		sample_t x1;
		sample_t x2;
		sample_t y1;
		sample_t y2;
	} tap_t;

	typedef struct packed {
		coef_val_t b0;
		coef_val_t b1;
		coef_val_t b2;
		coef_val_t a1;
		coef_val_t a2;
	} coef_t;

endpackage
`default_nettype wire

### src/bqf_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqf_mac
// Direct form I biquad sum of five products, rounded and saturated to Q1.23.
// ----------------------------------------------------------------------------
module bqf_mac (
	input  bqf_pkg::coef_t   coef,
	input  bqf_pkg::sample_t x,
	input  bqf_pkg::tap_t    taps,
	output bqf_pkg::sample_t y
);
	import bqf_pkg::*;

	localparam int PROD_W = SAMPLE_W + COEF_W;
	localparam int ACC_W  = PROD_W + 4;
	localparam int FRAC_W = 28;
	localparam int Q_W    = ACC_W - FRAC_W;

	localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(64'sd134217728);

	logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
	logic signed [ACC_W-1:0]  acc, rnd;
	logic signed [Q_W-1:0]    q;

	assign p_b0 = coef.b0 * x;
	assign p_b1 = coef.b1 * taps.x1;
	assign p_b2 = coef.b2 * taps.x2;
	assign p_a1 = coef.a1 * taps.y1;
	assign p_a2 = coef.a2 * taps.y2;

	assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2) - ACC_W'(p_a1) - ACC_W'(p_a2);
	assign rnd = acc + RND_BIAS;
	assign q   = signed'(rnd[ACC_W-1:FRAC_W]);

	always_comb begin
		if ((q[Q_W-1:SAMPLE_W-1] == '0) || (q[Q_W-1:SAMPLE_W-1] == '1)) begin
			y = q[SAMPLE_W-1:0];
		end else if (q[Q_W-1]) begin
			y = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			y = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

endmodule
`default_nettype wire

### src/bqf_state.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqf_state
// Per-channel delay line store: one write and one registered read per cycle,
// entry valid bits for reset, write-to-read forwarding.
// ----------------------------------------------------------------------------
module bqf_state #(
	parameter int MAX_CHANNELS = bqf_pkg::MAX_CHANNELS_DEF,
	parameter int CH_W         = 3
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  rd_en,
	input  wire [CH_W-1:0]       rd_addr,
	input  wire                  wr_en,
	input  wire [CH_W-1:0]       wr_addr,
	input  bqf_pkg::tap_t        wr_taps,
	output bqf_pkg::tap_t        rd_taps
);
	import bqf_pkg::*;

	tap_t                    mem [MAX_CHANNELS];
	logic [MAX_CHANNELS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_taps;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// forward a write to the same channel, else read the store
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_taps <= wr_taps;
			end else if (valid_q[rd_addr]) begin
				rd_taps <= mem[rd_addr];
			end else begin
				rd_taps <= '0;
			end
		end
	end

endmodule
`default_nettype wire

### src/multichannel_biquad_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_biquad_filter
// Direct form I biquad over interleaved channels, one sample per beat.
// ----------------------------------------------------------------------------
// Pipeline: an accepted beat waits in the input stage, then loads the result register.
// Throughput: one beat per cycle unless the output stalls; the channel's delay
// line is read when the beat is taken and written back, forwarded, at result load.
// Reset: coefficients to pass-through, one channel, counter and all delay
// lines to zero; no clearing pass.
// ----------------------------------------------------------------------------
module multichannel_biquad_filter #(
	parameter int MAX_CHANNELS = bqf_pkg::MAX_CHANNELS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire [bqf_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire [bqf_pkg::COEF_W-1:0]            cfg_data,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire signed [bqf_pkg::SAMPLE_W-1:0]   sample_in,
	input  wire                                  last_in_block,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic signed [bqf_pkg::SAMPLE_W-1:0]  sample_out,
	output logic [bqf_pkg::CHIDX_W-1:0]          channel_index,
	output logic                                 block_end
);
	import bqf_pkg::*;

	localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CMP_W = (CH_W + 1 > COUNT_W) ? CH_W + 1 : COUNT_W;
	localparam logic [CMP_W-1:0] MAX_N = CMP_W'(MAX_CHANNELS);

	coef_t              coef_q;
	logic [COUNT_W-1:0] count_q;
	logic [CH_W-1:0]    counter_q;

	logic               v_s1;
	sample_t            sample_s1;
	logic               last_s1;
	logic [CH_W-1:0]    ch_s1;
	tap_t               taps_s1;

	logic               accept, adv;
	logic [CMP_W-1:0]   count_ext, active_n, ctr_ext, ch_acc, ch_inc, ch_out_ext;
	sample_t            y;
	tap_t               new_taps;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b0 <= COEF_UNITY;
			coef_q.b1 <= '0;
			coef_q.b2 <= '0;
			coef_q.a1 <= '0;
			coef_q.a2 <= '0;
			count_q   <= COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_B0:    coef_q.b0 <= cfg_data;
				REG_B1:    coef_q.b1 <= cfg_data;
				REG_B2:    coef_q.b2 <= cfg_data;
				REG_A1:    coef_q.a1 <= cfg_data;
				REG_A2:    coef_q.a2 <= cfg_data;
				REG_COUNT: count_q   <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// channel sequencing
	always_comb begin
		count_ext = CMP_W'(count_q);
		if (count_q == '0) begin
			active_n = CMP_W'(1);
		end else if (count_ext > MAX_N) begin
			active_n = MAX_N;
		end else begin
			active_n = count_ext;
		end
		ctr_ext = CMP_W'(counter_q);
		ch_acc  = (ctr_ext >= active_n) ? '0 : ctr_ext;
		ch_inc  = ch_acc + CMP_W'(1);
	end

	assign adv      = v_s1 && (!out_valid || out_ready);
	assign in_ready = !v_s1 || adv;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			v_s1      <= 1'b0;
		end else begin
			if (accept) begin
				counter_q <= (ch_inc >= active_n) ? '0 : ch_inc[CH_W-1:0];
				v_s1      <= 1'b1;
			end else if (adv) begin
				v_s1      <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample_in;
			last_s1   <= last_in_block;
			ch_s1     <= ch_acc[CH_W-1:0];
		end
	end

	bqf_state #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.CH_W         (CH_W)
	) u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (ch_acc[CH_W-1:0]),
		.wr_en   (adv),
		.wr_addr (ch_s1),
		.wr_taps (new_taps),
		.rd_taps (taps_s1)
	);

	bqf_mac u_mac (
		.coef (coef_q),
		.x    (sample_s1),
		.taps (taps_s1),
		.y    (y)
	);

	always_comb begin
		new_taps.x1 = sample_s1;
		new_taps.x2 = taps_s1.x1;
		new_taps.y1 = y;
		new_taps.y2 = taps_s1.y1;
	end

	assign ch_out_ext = CMP_W'(ch_s1);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_out    <= y;
			channel_index <= ch_out_ext[CHIDX_W-1:0];
			block_end     <= last_s1;
		end
	end

`ifndef SYNTHESIS
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted beat did not reach the input stage");

	a_adv_offers: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("advanced beat not offered on the output");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !accept) |=> !v_s1)
		else $error("input stage kept a beat that had advanced");

	a_hold_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> (v_s1 && $stable(ch_s1) && $stable(sample_s1)))
		else $error("stalled input stage changed");
`endif

endmodule
`default_nettype wire
